### rtl/bdq_pkg.sv
`timescale 1ns / 1ps

package bdq_pkg;

  localparam int DEPTH   = 8;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int WORD_W  = 32;
  localparam int FILL_W  = 4;

  typedef enum logic [1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_BACK  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_BACK   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

  // (base + offset) modulo DEPTH, both operands below DEPTH
  function automatic logic [ADDR_W-1:0] ring_pos(input logic [ADDR_W-1:0] base,
                                                 input logic [CNT_W-1:0]  offset);
    logic [CNT_W+ADDR_W:0] sum;
    sum = {{(CNT_W+1){1'b0}}, base} + {{(ADDR_W+1){1'b0}}, offset};
    if (sum >= (CNT_W+ADDR_W+1)'(DEPTH)) begin
      sum = sum - (CNT_W+ADDR_W+1)'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

### rtl/bdq_store.sv
`timescale 1ns / 1ps

module bdq_store
  import bdq_pkg::*;
(
  input  logic              clk,
  input  mem_req_t          req,
  output logic [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

### rtl/bdq_ctrl.sv
`timescale 1ns / 1ps

module bdq_ctrl
  import bdq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_ready,
  input  logic [1:0]               action,
  input  logic signed [WORD_W-1:0] push_value,
  output logic                     result_valid,
  input  logic                     result_ready,
  output logic signed [WORD_W-1:0] pop_value,
  output logic [1:0]               status,
  output logic [FILL_W-1:0]        fill_level,
  output mem_req_t                 req,
  input  logic [WORD_W-1:0]        rd_data
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t             state, state_next;
  logic [ADDR_W-1:0]  head, head_next;
  logic [CNT_W-1:0]   count, count_next;
  status_t            stat_next;
  logic               accept;
  logic               is_push;
  logic               is_full;
  logic               is_empty;
  logic               pop_ok;
  logic [CNT_W+FILL_W-1:0] fill_ext;

  assign item_ready = (state == S_IDLE) && (!result_valid || result_ready);
  assign accept     = item_valid && item_ready;
  assign is_push    = (action == ACT_PUSH_FRONT) || (action == ACT_PUSH_BACK);
  assign is_full    = (count == CNT_W'(DEPTH));
  assign is_empty   = (count == '0);
  assign pop_ok     = accept && !is_push && !is_empty;

  always_comb begin
    head_next  = head;
    count_next = count;
    stat_next  = ST_OK;
    req        = '0;
    req.wr_data = push_value;
    unique case (action)
      ACT_PUSH_FRONT: begin
        if (is_full) begin
          stat_next = ST_FULL;
        end else begin
          head_next   = (head == '0) ? ADDR_W'(DEPTH - 1) : head - 1'b1;
          count_next  = count + 1'b1;
          req.wr_en   = accept;
          req.wr_addr = head_next;
        end
      end
      ACT_PUSH_BACK: begin
        if (is_full) begin
          stat_next = ST_FULL;
        end else begin
          count_next  = count + 1'b1;
          req.wr_en   = accept;
          req.wr_addr = ring_pos(head, count);
        end
      end
      ACT_POP_FRONT: begin
        if (is_empty) begin
          stat_next = ST_EMPTY;
        end else begin
          head_next   = ring_pos(head, CNT_W'(1));
          count_next  = count - 1'b1;
          req.rd_en   = accept;
          req.rd_addr = head;
        end
      end
      default: begin
        if (is_empty) begin
          stat_next = ST_EMPTY;
        end else begin
          count_next  = count - 1'b1;
          req.rd_en   = accept;
          req.rd_addr = ring_pos(head, count - 1'b1);
        end
      end
    endcase
  end

  assign fill_ext = {{FILL_W{1'b0}}, count_next};

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (pop_ok) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      head         <= '0;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        head  <= head_next;
        count <= count_next;
      end
      priority if (state == S_READ) begin
        result_valid <= 1'b1;
      end else if (accept) begin
        result_valid <= !pop_ok;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // hold the result word; popped data is taken from the memory's read register in S_READ
  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      pop_value <= rd_data;
    end else if (accept) begin
      pop_value  <= '0;
      status     <= stat_next;
      fill_level <= fill_ext[FILL_W-1:0];
    end
  end

endmodule

### rtl/bounded_deque.sv
`timescale 1ns / 1ps
// Bounded double-ended queue of 32-bit signed words, DEPTH entries in a ring.
// Input channel (item_valid/item_ready): action selects push front, push back,
// pop front or pop back; push_value carries the word for pushes.
// Output channel (result_valid/result_ready): one result per word taken,
// giving pop_value (zero unless a pop succeeds), status (ok, full, empty)
// and fill_level after the step.
// Result timing: pushes and rejected operations present their result the
// cycle after acceptance; a successful pop reads the entry memory and takes
// the registered read data in S_READ, during which no new word is taken.
// Throughput: one push per cycle unless the receiver stalls.
// A new word is taken while the previous result is being taken in the same
// cycle; while the receiver stalls, the result register holds and the input
// side stops accepting.
// Reset empties the queue (head and fill count cleared); entry contents are
// left as they are and are never read before being written.

module bounded_deque
  import bdq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_ready,
  input  logic [1:0]               action,
  input  logic signed [WORD_W-1:0] push_value,
  output logic                     result_valid,
  input  logic                     result_ready,
  output logic signed [WORD_W-1:0] pop_value,
  output logic [1:0]               status,
  output logic [FILL_W-1:0]        fill_level
);

  mem_req_t          req;
  logic [WORD_W-1:0] rd_data;

  bdq_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .action       (action),
    .push_value   (push_value),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .pop_value    (pop_value),
    .status       (status),
    .fill_level   (fill_level),
    .req          (req),
    .rd_data      (rd_data)
  );

  bdq_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

endmodule
